>>> hdl/scc_pkg.sv
`default_nettype none

package scc_pkg;

   // Default sizes
   localparam int LINE_CHARS_DEF  = 31;
   localparam int MIN_CAPTURE_DEF = 1024;
   localparam int MAX_CAPTURE_DEF = 8192 * 2;

   // Reset values of the settings
   localparam int CAPTURE_LENGTH_RESET    = 2048;
   localparam int RATE_RESET              = 10000;
   localparam int TRIGGER_RESET           = 2048;
   localparam logic [19:0] RATE_MIN       = 20'd1000;
   localparam logic [19:0] RATE_MAX       = 20'd1000000;

   // Field widths
   localparam int REQ_DATA_W = 24;   // rx_byte 8, adc_sample 12, pad 4
   localparam int RSP_DATA_W = 40;   // reply_code 3, sample_word 16, sample_index 14, pad 7

   // Characters
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Command words, right-justified, first character in the highest used byte
   localparam int WORD_COUNT = 6;
   localparam int W_START    = 0;
   localparam int W_LEN      = 1;
   localparam int W_SRATE    = 2;
   localparam int W_TRIGLVL  = 3;
   localparam int W_WAIT     = 4;
   localparam int W_AUTO     = 5;

   localparam logic [71:0] WORD_TEXT [WORD_COUNT] = '{
      {32'd0, "START"},
      {40'd0, "LEN:"},
      {24'd0, "SRATE:"},
      {8'd0,  "TRIGLVL:"},
      "TRIG:WAIT",
      "TRIG:AUTO"
   };
   localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
      4'd5, 4'd4, 4'd6, 4'd8, 4'd9, 4'd9
   };

   // Number saturation limit
   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

   typedef enum logic [1:0] {
      FUNC_CMD    = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_TICK   = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      REPLY_LEN_OK    = 3'd0,
      REPLY_LEN_ERR   = 3'd1,
      REPLY_SRATE_OK  = 3'd2,
      REPLY_SRATE_ERR = 3'd3,
      REPLY_TRIG_OK   = 3'd4,
      REPLY_WAIT_OK   = 3'd5,
      REPLY_AUTO_OK   = 3'd6,
      REPLY_CMD_ERR   = 3'd7
   } reply_type;

   typedef enum logic {
      KIND_REPLY  = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      PARSE_BLANK,
      PARSE_DIGITS,
      PARSE_DONE
   } parse_type;

   // Character idx of a right-justified word of wlen characters
   function automatic logic [7:0] word_char(input logic [71:0] text,
                                            input logic [3:0] wlen,
                                            input logic [3:0] idx);
      logic [3:0]  back;
      logic [71:0] shifted;
      back    = wlen - idx - 4'd1;
      shifted = text >> {back, 3'b000};
      return shifted[7:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/scope_command_and_capture.sv
// Channel | direction | tdata (low bit up)                                   | tuser | tlast
// req_    | in        | rx_byte[7:0], adc_sample[19:8], zero pad             | func  | -
// rsp_    | out       | reply_code[2:0], sample_word[18:3],                  | kind  | last_sample
//         |           | sample_index[32:19], zero pad                        |       |
//
// One item per cycle unless stalled; a result is registered in the cycle after its transfer.
// Command lines are matched and their numbers parsed character by character as bytes arrive,
// so CR or LF only applies the line and selects any reply from the running match and parse state.
// Reset is synchronous and active high; it clears the line, settings and capture state.
// req_tready is high while the output register is empty or being emptied this cycle.
`default_nettype none

module scope_command_and_capture #(
   parameter int LINE_CHARS  = scc_pkg::LINE_CHARS_DEF,
   parameter int MIN_CAPTURE = scc_pkg::MIN_CAPTURE_DEF,
   parameter int MAX_CAPTURE = scc_pkg::MAX_CAPTURE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [scc_pkg::REQ_DATA_W-1:0]  req_tdata,  // rx_byte, adc_sample
   input  wire logic [1:0]                      req_tuser,  // func
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [scc_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // reply_code, sample_word, sample_index
   output logic                                 rsp_tuser,  // kind
   output logic                                 rsp_tlast   // last_sample
);
   import scc_pkg::*;

   localparam int LEN_W   = $clog2(LINE_CHARS + 1);
   localparam int CAP_TOP = (MAX_CAPTURE > CAPTURE_LENGTH_RESET) ? MAX_CAPTURE
                                                                 : CAPTURE_LENGTH_RESET;
   localparam int CAP_W   = $clog2(CAP_TOP + 1);

   // Line state
   logic [LEN_W-1:0]      line_length_ff, line_length_in;
   logic [LEN_W-1:0]      text_len_ff, text_len_in;
   logic                  zero_seen_ff, zero_seen_in;
   logic [WORD_COUNT-1:0] match_ff, match_in;
   parse_type             parse_ff, parse_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           mag_ff, mag_in;

   // Settings and capture state
   logic [CAP_W-1:0]      capture_length_ff, capture_length_in;
   logic [19:0]           rate_ff, rate_in;
   logic [15:0]           threshold_ff, threshold_in;
   logic                  auto_ff, auto_in;
   logic                  capturing_ff, capturing_in;
   logic [CAP_W-1:0]      capture_pos_ff, capture_pos_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              kind_ff, kind_in;
   reply_type             code_ff, code_in;
   logic [15:0]           word_ff, word_in;
   logic [13:0]           index_ff, index_in;
   logic                  last_ff, last_in;

   // Decoded input
   logic                  accept;
   logic [7:0]            ch;
   logic [11:0]           sample;
   logic                  is_blank, is_sign, is_digit;
   logic [3:0]            digit;
   logic [35:0]           mag_next;
   logic [31:0]           mag_acc;
   logic                  num_active;
   logic [WORD_COUNT-1:0] found;
   logic                  len_ok, rate_ok;
   logic [15:0]           level;
   logic [CAP_W-1:0]      pos_next;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata[7:0];
   assign sample     = req_tdata[19:8];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, index_ff, word_ff, code_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   // Character classes and one digit step of the running number
   always_comb begin
      is_blank   = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_VT) ||
                   (ch == CHAR_FF);
      is_sign    = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
      is_digit   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      digit      = 4'(ch - CHAR_ZERO);
      mag_next   = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1) + 36'(digit);
      mag_acc    = (mag_next > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_next[31:0];
      num_active = (match_ff[W_LEN]     && (line_length_ff >= LEN_W'(WORD_LEN[W_LEN])))   ||
                   (match_ff[W_SRATE]   && (line_length_ff >= LEN_W'(WORD_LEN[W_SRATE]))) ||
                   (match_ff[W_TRIGLVL] && (line_length_ff >= LEN_W'(WORD_LEN[W_TRIGLVL])));
   end

   // Evaluate the finished line from the running match and parse state
   always_comb begin
      for (int w = 0; w < WORD_COUNT; w++) begin
         found[w] = match_ff[w] && (line_length_ff >= LEN_W'(WORD_LEN[w]));
      end
      found[W_WAIT] = found[W_WAIT] && (text_len_ff == LEN_W'(WORD_LEN[W_WAIT]));
      found[W_AUTO] = found[W_AUTO] && (text_len_ff == LEN_W'(WORD_LEN[W_AUTO]));
      len_ok  = !neg_ff && (mag_ff >= 32'(MIN_CAPTURE)) && (mag_ff <= 32'(MAX_CAPTURE)) &&
                ((mag_ff & (mag_ff - 32'd1)) == 32'd0);
      rate_ok = !neg_ff && (mag_ff >= 32'(RATE_MIN)) && (mag_ff <= 32'(RATE_MAX));
      if (neg_ff) begin
         level = 16'(~mag_ff + 32'd1);
      end else if (mag_ff == MAG_LIMIT) begin
         level = 16'hFFFF;
      end else begin
         level = mag_ff[15:0];
      end
      pos_next = capture_pos_ff + CAP_W'(1);
   end

   // Next state and result
   always_comb begin
      line_length_in    = line_length_ff;
      text_len_in       = text_len_ff;
      zero_seen_in      = zero_seen_ff;
      match_in          = match_ff;
      parse_in          = parse_ff;
      neg_in            = neg_ff;
      mag_in            = mag_ff;
      capture_length_in = capture_length_ff;
      rate_in           = rate_ff;
      threshold_in      = threshold_ff;
      auto_in           = auto_ff;
      capturing_in      = capturing_ff;
      capture_pos_in    = capture_pos_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      kind_in           = kind_ff;
      code_in           = code_ff;
      word_in           = word_ff;
      index_in          = index_ff;
      last_in           = last_ff;

      if (accept) begin
         case (req_tuser)
            FUNC_CMD: begin
               if ((ch == CHAR_LF) || (ch == CHAR_CR)) begin
                  // Run the line, then clear it
                  kind_in  = KIND_REPLY;
                  word_in  = 16'd0;
                  index_in = 14'd0;
                  last_in  = 1'b0;
                  rsp_valid_in = 1'b1;
                  if (found[W_START]) begin
                     capture_pos_in = '0;
                     capturing_in   = 1'b1;
                     rsp_valid_in   = rsp_valid_ff && !rsp_tready;
                     kind_in        = kind_ff;
                     word_in        = word_ff;
                     index_in       = index_ff;
                     last_in        = last_ff;
                  end else if (found[W_LEN]) begin
                     if (len_ok) begin
                        capture_length_in = CAP_W'(mag_ff);
                        code_in = REPLY_LEN_OK;
                     end else begin
                        code_in = REPLY_LEN_ERR;
                     end
                  end else if (found[W_SRATE]) begin
                     if (rate_ok) begin
                        rate_in = mag_ff[19:0];
                        code_in = REPLY_SRATE_OK;
                     end else begin
                        code_in = REPLY_SRATE_ERR;
                     end
                  end else if (found[W_TRIGLVL]) begin
                     threshold_in = level;
                     code_in      = REPLY_TRIG_OK;
                  end else if (found[W_WAIT]) begin
                     auto_in = 1'b0;
                     code_in = REPLY_WAIT_OK;
                  end else if (found[W_AUTO]) begin
                     auto_in = 1'b1;
                     code_in = REPLY_AUTO_OK;
                  end else begin
                     code_in = REPLY_CMD_ERR;
                  end
                  line_length_in = '0;
                  text_len_in    = '0;
                  zero_seen_in   = 1'b0;
                  match_in       = '1;
                  parse_in       = PARSE_BLANK;
                  neg_in         = 1'b0;
                  mag_in         = 32'd0;
               end else if (line_length_ff < LEN_W'(LINE_CHARS)) begin
                  // Take the character; drop it when the line is full
                  line_length_in = line_length_ff + LEN_W'(1);
                  if (ch == CHAR_NUL) begin
                     zero_seen_in = 1'b1;
                  end else if (!zero_seen_ff) begin
                     text_len_in = text_len_ff + LEN_W'(1);
                  end
                  for (int w = 0; w < WORD_COUNT; w++) begin
                     if ((line_length_ff < LEN_W'(WORD_LEN[w])) &&
                         (ch != word_char(WORD_TEXT[w], WORD_LEN[w], 4'(line_length_ff)))) begin
                        match_in[w] = 1'b0;
                     end
                  end
                  if (num_active) begin
                     case (parse_ff)
                        PARSE_BLANK: begin
                           if (is_digit) begin
                              parse_in = PARSE_DIGITS;
                              mag_in   = 32'(digit);
                           end else if (is_sign) begin
                              parse_in = PARSE_DIGITS;
                              neg_in   = (ch == CHAR_MINUS);
                           end else if (!is_blank) begin
                              parse_in = PARSE_DONE;
                           end
                        end
                        PARSE_DIGITS: begin
                           if (is_digit) begin
                              mag_in = mag_acc;
                           end else begin
                              parse_in = PARSE_DONE;
                           end
                        end
                        default: begin
                           parse_in = PARSE_DONE;
                        end
                     endcase
                  end
               end
            end
            FUNC_SAMPLE: begin
               if (capturing_ff) begin
                  // Emit a captured sample, byte-swapped
                  if (capture_pos_ff < capture_length_ff) begin
                     rsp_valid_in   = 1'b1;
                     kind_in        = KIND_SAMPLE;
                     code_in        = REPLY_LEN_OK;
                     word_in        = {sample[7:0], 4'd0, sample[11:8]};
                     index_in       = 14'(capture_pos_ff);
                     capture_pos_in = pos_next;
                     last_in        = (pos_next >= capture_length_ff);
                     if (pos_next >= capture_length_ff) begin
                        capturing_in = 1'b0;
                     end
                  end
               end else if (!auto_ff && ({4'd0, sample} > threshold_ff)) begin
                  // Fire the level trigger
                  capture_pos_in = '0;
                  capturing_in   = 1'b1;
               end
            end
            FUNC_TICK: begin
               capture_pos_in = '0;
               capturing_in   = 1'b1;
            end
            default: begin
               capturing_in = capturing_ff;
            end
         endcase
      end
   end

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= PARSE_BLANK;
      end else begin
         parse_ff <= parse_in;
      end
   end

   // Control and settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff    <= '0;
         text_len_ff       <= '0;
         zero_seen_ff      <= 1'b0;
         match_ff          <= '1;
         neg_ff            <= 1'b0;
         mag_ff            <= 32'd0;
         capture_length_ff <= CAP_W'(CAPTURE_LENGTH_RESET);
         rate_ff           <= 20'(RATE_RESET);
         threshold_ff      <= 16'(TRIGGER_RESET);
         auto_ff           <= 1'b1;
         capturing_ff      <= 1'b0;
         capture_pos_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         line_length_ff    <= line_length_in;
         text_len_ff       <= text_len_in;
         zero_seen_ff      <= zero_seen_in;
         match_ff          <= match_in;
         neg_ff            <= neg_in;
         mag_ff            <= mag_in;
         capture_length_ff <= capture_length_in;
         rate_ff           <= rate_in;
         threshold_ff      <= threshold_in;
         auto_ff           <= auto_in;
         capturing_ff      <= capturing_in;
         capture_pos_ff    <= capture_pos_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      code_ff  <= code_in;
      word_ff  <= word_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   // Checks
   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      (line_length_ff <= LEN_W'(LINE_CHARS)) && (text_len_ff <= line_length_ff))
      else $error("line length out of bounds");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> (index_ff == 14'(capture_length_ff - CAP_W'(1))))
      else $error("last sample not at end of capture");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == FUNC_SAMPLE) && capturing_ff &&
      (pos_next == capture_length_ff) |=> !capturing_ff && last_ff && rsp_valid_ff)
      else $error("capture did not end on its last sample");

   a_reply_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == KIND_REPLY) |-> (word_ff == 16'd0) && !last_ff)
      else $error("reply carries sample fields");

endmodule

`default_nettype wire
